### rtl/hir_pkg.sv
// ============================================================================
// hir_pkg: shared types, constants and helpers for the hue to RGB converter
// Fixed-point constants in 1/255 units, pipeline payload types and
// divide-by-255 helpers.
// ============================================================================
package hir_pkg;

    // Widths of the item fields and registers
    localparam int IDX_W = 10;
    localparam int CH_W  = 8;
    localparam int CFG_INDEX_W = 8;

    // Fixed-point unit (1.0 == 255) and its square
    localparam logic [7:0]  HUE_UNIT    = 8'd255;
    localparam logic [15:0] HUE_UNIT_SQ = 16'd65025;

    // floor(x / 65025) == (x * RECIP_UNIT_SQ) >> RECIP_SHIFT for any x < 2**24
    localparam logic [24:0] RECIP_UNIT_SQ = 25'd16909061;
    localparam int          RECIP_SHIFT   = 40;

    // Register reset values (0.8 in 1/255 units)
    localparam logic [7:0] SAT_RESET = 8'd204;
    localparam logic [7:0] BRI_RESET = 8'd204;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 8'd1;

    // Hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } hir_sector_t;

    // Stage 1 -> 2: sector and fraction of the hue
    typedef struct packed {
        hir_sector_t sector;
        logic [7:0]  frac;
    } hir_dec_t;

    // Stage 3 -> 4: scaled numerators for q and t, finished p
    typedef struct packed {
        hir_sector_t sector;
        logic [23:0] q_num;
        logic [23:0] t_num;
        logic [7:0]  p;
    } hir_chroma_t;

    // floor(x / 255), exact for x < 65535
    function automatic logic [8:0] div255_16(input logic [15:0] x);
        logic [16:0] acc;
        acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return acc[16:8];
    endfunction

    // w mod 6 for w in 0..24, three compare-subtract steps
    function automatic hir_sector_t mod6(input logic [4:0] w);
        logic [4:0] r;
        r = w;
        if (r >= 5'd24) r = r - 5'd24;
        if (r >= 5'd12) r = r - 5'd12;
        if (r >= 5'd6)  r = r - 5'd6;
        return hir_sector_t'(r[2:0]);
    endfunction

endpackage

### rtl/hir_hue_decode.sv
// ============================================================================
// hir_hue_decode: hue index to sector and fraction (pipeline stage 1)
// Splits 6*index by 255 into a sector (mod 6) and a fraction in 1/255 steps.
// ============================================================================
module hir_hue_decode (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [hir_pkg::IDX_W-1:0] color_index,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hir_pkg::hir_dec_t         out_data
);
    import hir_pkg::*;

    logic        valid_reg, valid_next;
    hir_dec_t    data_reg, data_next;
    logic [12:0] scaled;
    logic [8:0]  whole_full;
    logic [4:0]  whole;
    logic [12:0] whole_x255;
    logic [12:0] rem;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        scaled     = {1'b0, color_index, 2'b00} + {2'b00, color_index, 1'b0};
        whole_full = div255_16({3'd0, scaled});
        whole      = whole_full[4:0];
        whole_x255 = {whole, 8'd0} - {8'd0, whole};
        rem        = scaled - whole_x255;
        data_next.sector = mod6(whole);
        data_next.frac   = rem[7:0];
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    // fraction is a remainder of /255, never 255
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.frac != 8'hFF))
        else $error("hue fraction out of range");
`endif

endmodule

### rtl/hir_chroma.sv
// ============================================================================
// hir_chroma: p, q and t numerators (pipeline stages 2 and 3)
// Stage 2 forms the 8x8 products with saturation, stage 3 scales by
// brightness and finishes p.
// ============================================================================
module hir_chroma (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             saturation,
    input  logic [7:0]             brightness,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hir_pkg::hir_dec_t      in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hir_pkg::hir_chroma_t   out_data
);
    import hir_pkg::*;

    // stage 2
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_ready;
    hir_sector_t s2_sector_reg;
    logic [15:0] s2_fs_reg, s2_fs_next;     // f * s
    logic [15:0] s2_gs_reg, s2_gs_next;     // (255 - f) * s
    logic [15:0] s2_pp_reg, s2_pp_next;     // v * (255 - s)

    // stage 3
    logic        s3_valid_reg, s3_valid_next;
    hir_chroma_t s3_data_reg, s3_data_next;
    logic [8:0]  p_full;

    assign s2_ready = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s2_ready;

    always_comb begin
        s2_fs_next = {8'd0, in_data.frac} * {8'd0, saturation};
        s2_gs_next = {8'd0, HUE_UNIT - in_data.frac} * {8'd0, saturation};
        s2_pp_next = {8'd0, brightness} * {8'd0, HUE_UNIT - saturation};
        s2_valid_next = in_ready ? in_valid : s2_valid_reg;
    end

    always_comb begin
        p_full = div255_16(s2_pp_reg);
        s3_data_next.sector = s2_sector_reg;
        s3_data_next.q_num  = {16'd0, brightness} * {8'd0, HUE_UNIT_SQ - s2_fs_reg};
        s3_data_next.t_num  = {16'd0, brightness} * {8'd0, HUE_UNIT_SQ - s2_gs_reg};
        s3_data_next.p      = p_full[7:0];
        s3_valid_next = s2_ready ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s2_sector_reg <= in_data.sector;
            s2_fs_reg     <= s2_fs_next;
            s2_gs_reg     <= s2_gs_next;
            s2_pp_reg     <= s2_pp_next;
        end
        if (s2_ready && s2_valid_reg) begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

### rtl/hir_rgb_route.sv
// ============================================================================
// hir_rgb_route: final scaling and channel routing (pipeline stage 4)
// Divides the q and t numerators by 65025 through a reciprocal multiply and
// routes v, p, q, t to red, green and blue by sector into the output register.
// ============================================================================
module hir_rgb_route (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [7:0]                brightness,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hir_pkg::hir_chroma_t      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [hir_pkg::CH_W-1:0]  red,
    output logic [hir_pkg::CH_W-1:0]  green,
    output logic [hir_pkg::CH_W-1:0]  blue
);
    import hir_pkg::*;

    logic        valid_reg, valid_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [48:0] q_prod;
    logic [48:0] t_prod;
    logic [7:0]  q;
    logic [7:0]  t;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        q_prod = {25'd0, in_data.q_num} * {24'd0, RECIP_UNIT_SQ};
        t_prod = {25'd0, in_data.t_num} * {24'd0, RECIP_UNIT_SQ};
        q = q_prod[RECIP_SHIFT +: 8];
        t = t_prod[RECIP_SHIFT +: 8];
        unique case (in_data.sector)
            SEC_RED_YEL: begin
                red_next = brightness; green_next = t;          blue_next = in_data.p;
            end
            SEC_YEL_GRN: begin
                red_next = q;          green_next = brightness; blue_next = in_data.p;
            end
            SEC_GRN_CYN: begin
                red_next = in_data.p;  green_next = brightness; blue_next = t;
            end
            SEC_CYN_BLU: begin
                red_next = in_data.p;  green_next = q;          blue_next = brightness;
            end
            SEC_BLU_MAG: begin
                red_next = t;          green_next = in_data.p;  blue_next = brightness;
            end
            default: begin
                red_next = brightness; green_next = in_data.p;  blue_next = q;
            end
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

### rtl/hue_index_to_rgb_core.sv
// ============================================================================
// hue_index_to_rgb_core: hue index to RGB color converter
// HSV to RGB with programmable saturation and brightness, four-stage pipeline.
// ============================================================================
// Takes one 10-bit hue index per beat and returns one RGB triple per beat.
// The hue is index/255 of a turn (indices of 255 and up wrap); saturation
// and brightness come from two 8-bit registers in 1/255 units, both 0.8
// (204) after reset. All math is integer, rounded down. Throughput is one
// beat per clock while m_tready is high; latency is four register stages
// from input accept to m_tvalid. The stages are hue decode (divide by
// 255), saturation products, brightness products, and the reciprocal
// multiply for /65025 plus channel routing into the output register.
// Each stage has its own valid bit and a stage loads whenever it is empty
// or the one after it moves, so bubbles are squeezed out and a stalled
// m_tready holds results without loss. Registers may only be written
// while the pipeline is empty; index 0 is saturation, index 1 brightness,
// other indexes are ignored. cfg_ready is always high.
// ============================================================================
module hue_index_to_rgb_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [9:0] color_index, [15:10] zero
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import hir_pkg::*;

    logic [7:0]  saturation_reg, saturation_next;
    logic [7:0]  brightness_reg, brightness_next;

    logic        dec_valid, dec_ready;
    hir_dec_t    dec_data;
    logic        chr_valid, chr_ready;
    hir_chroma_t chr_data;
    logic [7:0]  red, green, blue;

    // ---- configuration registers ----
    assign cfg_ready = 1'b1;

    always_comb begin
        saturation_next = saturation_reg;
        brightness_next = brightness_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_SATURATION) begin
                saturation_next = cfg_data;
            end else if (cfg_index == CFG_BRIGHTNESS) begin
                brightness_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saturation_reg <= SAT_RESET;
            brightness_reg <= BRI_RESET;
        end else begin
            saturation_reg <= saturation_next;
            brightness_reg <= brightness_next;
        end
    end

    // ---- stage 1: sector and fraction ----
    hir_hue_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .color_index (s_tdata[IDX_W-1:0]),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .out_data    (dec_data)
    );

    // ---- stages 2 and 3: p, q, t numerators ----
    hir_chroma u_chroma (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .saturation (saturation_reg),
        .brightness (brightness_reg),
        .in_valid   (dec_valid),
        .in_ready   (dec_ready),
        .in_data    (dec_data),
        .out_valid  (chr_valid),
        .out_ready  (chr_ready),
        .out_data   (chr_data)
    );

    // ---- stage 4: /65025 and routing, output register ----
    hir_rgb_route u_route (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .brightness (brightness_reg),
        .in_valid   (chr_valid),
        .in_ready   (chr_ready),
        .in_data    (chr_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign m_tdata = {blue, green, red};

`ifndef ASSERT_OFF
    // a ready sink never stalls the source: every stage drains
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // registers come out of reset at 0.8
    a_reset_values: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> (saturation_reg == SAT_RESET) && (brightness_reg == BRI_RESET))
        else $error("config registers not at reset value");

    // writes to an unknown index leave both registers untouched
    a_unknown_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && (cfg_index != CFG_SATURATION)
            && (cfg_index != CFG_BRIGHTNESS))
        |=> $stable(saturation_reg) && $stable(brightness_reg))
        else $error("write to unknown register index changed state");
`endif

endmodule

### tb/hue_index_to_rgb_core_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// hue_index_to_rgb_core_checker: color predictor and scoreboard
// Watches the input, result and register channels of the hue to RGB core.
// It keeps its own copy of saturation and brightness and predicts each RGB
// triple. Each result beat is compared field by field with the oldest
// prediction.
// ============================================================================
module hue_index_to_rgb_core_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            drain_done,
    output int                              error_count,
    output int                              pending,
    output int                              colors_checked
);
    import hir_pkg::*;

    localparam int unsigned UNIT    = 255;
    localparam int unsigned UNIT_SQ = UNIT * UNIT;

    // packed so that red sits in the low byte, as on m_tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct {
        logic [9:0] hue;
        rgb_t       rgb;
    } color_entry_t;

    color_entry_t expected_colors[$];
    logic [7:0]   sat_copy;
    logic [7:0]   bri_copy;
    bit           drained;

    initial begin
        error_count    = 0;
        pending        = 0;
        colors_checked = 0;
        drained        = 1'b0;
    end

    // HSV to RGB, integer math rounded down
    function automatic rgb_t hue_to_rgb(input logic [9:0] hue, input logic [7:0] sat,
                                        input logic [7:0] bri);
        int unsigned scaled;
        int unsigned frac;
        int unsigned s;
        int unsigned v;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        hir_sector_t sector;
        rgb_t        c;
        scaled = 6 * int'(hue);
        frac   = scaled % UNIT;
        sector = hir_sector_t'((scaled / UNIT) % 6);
        s      = sat;
        v      = bri;
        p      = (v * (UNIT - s)) / UNIT;
        q      = (v * (UNIT_SQ - frac * s)) / UNIT_SQ;
        t      = (v * (UNIT_SQ - (UNIT - frac) * s)) / UNIT_SQ;
        case (sector)
            SEC_RED_YEL: c = '{blue: p[7:0], green: t[7:0], red: v[7:0]};
            SEC_YEL_GRN: c = '{blue: p[7:0], green: v[7:0], red: q[7:0]};
            SEC_GRN_CYN: c = '{blue: t[7:0], green: v[7:0], red: p[7:0]};
            SEC_CYN_BLU: c = '{blue: v[7:0], green: q[7:0], red: p[7:0]};
            SEC_BLU_MAG: c = '{blue: v[7:0], green: p[7:0], red: t[7:0]};
            default:     c = '{blue: q[7:0], green: p[7:0], red: v[7:0]};
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("  mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        color_entry_t want;
        color_entry_t entry;
        rgb_t         seen;
        if (!aresetn) begin
            expected_colors.delete();
            sat_copy <= SAT_RESET;
            bri_copy <= BRI_RESET;
            pending  <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SATURATION: sat_copy <= cfg_data;
                    CFG_BRIGHTNESS: bri_copy <= cfg_data;
                    default: ;
                endcase
            end
            // results first, so a stray beat never pairs with this edge's input
            if (m_tvalid && m_tready) begin
                seen = m_tdata;
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
                end else begin
                    want = expected_colors.pop_front();
                    colors_checked++;
                    if (seen.red !== want.rgb.red)
                        report_mismatch($sformatf("hue %0d red %h, want %h",
                                                  want.hue, seen.red, want.rgb.red));
                    if (seen.green !== want.rgb.green)
                        report_mismatch($sformatf("hue %0d green %h, want %h",
                                                  want.hue, seen.green, want.rgb.green));
                    if (seen.blue !== want.rgb.blue)
                        report_mismatch($sformatf("hue %0d blue %h, want %h",
                                                  want.hue, seen.blue, want.rgb.blue));
                end
            end
            if (s_tvalid && s_tready) begin
                entry.hue = s_tdata[9:0];
                entry.rgb = hue_to_rgb(s_tdata[9:0], sat_copy, bri_copy);
                expected_colors.push_back(entry);
            end
            if (drain_done && !drained) begin
                drained = 1'b1;
                foreach (expected_colors[i])
                    report_mismatch($sformatf("no result for hue %0d",
                                              expected_colors[i].hue));
                expected_colors.delete();
            end
            pending <= expected_colors.size();
        end
    end

endmodule

### tb/hue_index_to_rgb_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// hue_index_to_rgb_core_test: testbench top for the hue to RGB core
// Drives hue beats and register writes, stalls both streams in random
// bursts and leaves checking to the scoreboard beside the core.
// ============================================================================
module hue_index_to_rgb_core_test;
    import hir_pkg::*;

    localparam int RESET_CYCLES     = 10;
    localparam int PHASES           = 11;      // register settings, first is reset
    localparam int RANDOM_PER_PHASE = 105;
    localparam int REROLL_EVERY     = 25;      // items between idle-mode changes
    localparam int MAX_IDLE         = 18;      // longest gap or stall burst
    localparam int DRAIN_CYCLES     = 12;      // margin for the pipeline to drain
    localparam int CYCLE_LIMIT      = 400000;  // ~10x the slowest legal run

    // any index past the last register is a no-op write
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_BRIGHTNESS + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_MAX    = '1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;    // [9:0] color_index, [15:10] zero
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;           // [7:0] red, [15:8] green, [23:16] blue
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    logic drain_done = 1'b0;
    int   error_count;
    int   pending;
    int   colors_checked;
    int   cycle_count = 0;
    int   hues_sent   = 0;

    // idle controls: gap_on is used by the stimulus process only,
    // stall_on feeds the m_tready process and so moves on clock edges
    bit gap_on   = 1'b0;
    bit stall_on = 1'b0;
    bit quiet    = 1'b0;   // last phase runs flat out
    int stall_left = 0;

    // sector edges, wrap points, bit patterns and both ends of the index
    logic [9:0] corner_hues [0:21] = '{
        10'd0,   10'd1,   10'd42,  10'd43,  10'd85,   10'd128,  10'd170, 10'd212,
        10'd213, 10'd254, 10'd255, 10'd256, 10'd297,  10'd341,  10'd511, 10'd512,
        10'd682, 10'd767, 10'd1019, 10'd1020, 10'd1022, 10'd1023
    };

    // extremes first, then random settings
    logic [7:0] sat_plan [1:5] = '{8'd0,   8'd255, 8'd255, 8'd0, 8'd1};
    logic [7:0] bri_plan [1:5] = '{8'd255, 8'd255, 8'd0,   8'd0, 8'd254};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hue_index_to_rgb_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hue_index_to_rgb_core_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .drain_done     (drain_done),
        .error_count    (error_count),
        .pending        (pending),
        .colors_checked (colors_checked)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("[hue_index_to_rgb_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts, capped by MAX_IDLE;
    // a burst in progress ends as soon as stalls are switched off
    always @(posedge aclk) begin
        if (stall_left > 0 && stall_on) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, MAX_IDLE) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // new idle mix for the next stretch; some stretches have none
    task automatic reroll_idle();
        gap_on   = !quiet && $urandom_range(0, 2) != 0;
        stall_on <= !quiet && $urandom_range(0, 2) != 0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one beat; s_tvalid stays high across back-to-back beats
    task automatic send_hue(input logic [9:0] hue);
        if (gap_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, hue};
        do @(posedge aclk); while (!s_tready);
        hues_sent++;
    endtask

    // wait until every accepted beat has its result; the first edge lets the
    // scoreboard see the last input
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // mostly uniform, a quarter near the sector edges (6*hue crossing 255*k)
    function automatic logic [9:0] pick_hue();
        int k;
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, 24);
            return 10'((255 * k) / 6 + $urandom_range(0, 2));
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % REROLL_EVERY == 0) reroll_idle();
            send_hue(pick_hue());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting (0.8, 0.8): corners, then random
        reroll_idle();
        foreach (corner_hues[i]) send_hue(corner_hues[i]);
        run_random(RANDOM_PER_PHASE);

        for (int ph = 1; ph < PHASES; ph++) begin
            wait_idle();
            quiet = (ph == PHASES - 1);
            if (quiet) begin
                gap_on   = 1'b0;
                stall_on <= 1'b0;
            end
            // a dropped write to an unused index must not disturb the registers
            write_reg(ph[0] ? CFG_INDEX_MAX
                            : CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_INDEX_MAX)),
                      8'($urandom_range(0, 255)));
            if (ph <= 5) begin
                write_reg(CFG_SATURATION, sat_plan[ph]);
                write_reg(CFG_BRIGHTNESS, bri_plan[ph]);
            end else begin
                write_reg(CFG_BRIGHTNESS, 8'($urandom_range(0, 255)));
                write_reg(CFG_SATURATION, 8'($urandom_range(0, 255)));
            end
            run_random(RANDOM_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        drain_done <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("sent %0d hue beats over %0d register settings, %0d colors checked",
                 hues_sent, PHASES, colors_checked);
        $display("random stall and gap bursts on both streams, last setting without idling");
        if (error_count == 0) begin
            $display("[hue_index_to_rgb_core] OK");
        end else begin
            $display("[hue_index_to_rgb_core] ERROR");
        end
        $finish;
    end

endmodule
